>>> hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, token kind codes and character helpers for the tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Default length of the lexeme buffer in characters.
  localparam int unsigned MAX_LEXEME_DEF = 32;

  // Token kinds.
  localparam logic [4:0] K_SEMI    = 5'd0;
  localparam logic [4:0] K_PLUS    = 5'd1;
  localparam logic [4:0] K_MINUS   = 5'd2;
  localparam logic [4:0] K_MUL     = 5'd3;
  localparam logic [4:0] K_LPAREN  = 5'd4;
  localparam logic [4:0] K_RPAREN  = 5'd5;
  localparam logic [4:0] K_LBRACK  = 5'd6;
  localparam logic [4:0] K_RBRACK  = 5'd7;
  localparam logic [4:0] K_LBRACE  = 5'd8;
  localparam logic [4:0] K_RBRACE  = 5'd9;
  localparam logic [4:0] K_DIV     = 5'd10;
  localparam logic [4:0] K_ASSIGN  = 5'd11;
  localparam logic [4:0] K_EQ      = 5'd12;
  localparam logic [4:0] K_GT      = 5'd13;
  localparam logic [4:0] K_GE      = 5'd14;
  localparam logic [4:0] K_LT      = 5'd15;
  localparam logic [4:0] K_LE      = 5'd16;
  localparam logic [4:0] K_NEQ     = 5'd17;
  localparam logic [4:0] K_INTLIT  = 5'd18;
  localparam logic [4:0] K_REALLIT = 5'd19;
  localparam logic [4:0] K_ID      = 5'd20;
  localparam logic [4:0] K_KW0     = 5'd21;

  // Keyword table, text right aligned with the first character highest.
  localparam int unsigned KW_NUM     = 7;
  localparam int unsigned KW_MAX_LEN = 6;
  localparam logic [47:0] KW_TEXT [KW_NUM] = '{
    "if", "else", "while", "read", "write", "int", "real"
  };
  localparam int unsigned KW_LEN [KW_NUM] = '{2, 4, 5, 4, 5, 3, 4};

  // Lexeme buffer operations.
  typedef enum logic [2:0] {
    BUF_NONE,
    BUF_BEGIN,
    BUF_APPEND,
    BUF_APPEND_DOT,
    BUF_CLEAR,
    BUF_RD_FIRST,
    BUF_RD_NEXT
  } buf_op_e;

  typedef struct packed {
    buf_op_e    op;
    logic [7:0] chr;
  } buf_cmd_t;

  typedef struct packed {
    logic       kw_hit;
    logic [2:0] kw_idx;
    logic       overflowed;
    logic       seen_dot;
    logic       rd_last;
    logic [7:0] rd_char;
  } buf_stat_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } sym_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  // Character p of keyword i, or zero past its end.
  function automatic logic [7:0] kw_char(input int unsigned i, input int unsigned p);
    logic [47:0] t;
    int unsigned n;
    t = KW_TEXT[i];
    n = KW_LEN[i];
    if (p < n) begin
      return t[8*(n-1-p) +: 8];
    end
    return 8'h00;
  endfunction

  // Symbols that always stand alone as a token.
  function automatic sym_t single_sym(input logic [7:0] c);
    sym_t s;
    s.hit  = 1'b1;
    s.kind = K_SEMI;
    case (c)
      ";":     s.kind = K_SEMI;
      "+":     s.kind = K_PLUS;
      "-":     s.kind = K_MINUS;
      "*":     s.kind = K_MUL;
      "(":     s.kind = K_LPAREN;
      ")":     s.kind = K_RPAREN;
      "[":     s.kind = K_LBRACK;
      "]":     s.kind = K_RBRACK;
      "{":     s.kind = K_LBRACE;
      "}":     s.kind = K_RBRACE;
      default: s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/sct_lexbuf.sv
// ----------------------------------------------------------------------------
// sct_lexbuf
// Lexeme buffer: character memory with registered read, length, flags and
// incremental keyword matching.
// ----------------------------------------------------------------------------
module sct_lexbuf import sct_pkg::*; #(
  parameter int unsigned MaxLexeme = MAX_LEXEME_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  buf_cmd_t  cmd_i,
  output buf_stat_t stat_o
);

  localparam int unsigned AddrW = $clog2(MaxLexeme);
  localparam int unsigned LenW  = $clog2(MaxLexeme + 1);

  logic [7:0]        mem_q [MaxLexeme];
  logic [7:0]        rdata_q;
  logic [LenW-1:0]   len_q, len_d;
  logic [AddrW-1:0]  rd_idx_q, rd_idx_d;
  logic              dot_q, dot_d;
  logic              ovf_q, ovf_d;
  logic [KW_NUM-1:0] kw_ok_q, kw_ok_d;
  logic [KW_NUM-1:0] kw_len_eq;
  logic              full;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic              re;
  logic [AddrW-1:0]  raddr;
  logic              pos_ok;

  assign full   = (len_q == LenW'(MaxLexeme));
  assign pos_ok = (len_q < LenW'(KW_MAX_LEN));

  always_comb begin
    len_d    = len_q;
    rd_idx_d = rd_idx_q;
    dot_d    = dot_q;
    ovf_d    = ovf_q;
    kw_ok_d  = kw_ok_q;
    we       = 1'b0;
    waddr    = len_q[AddrW-1:0];
    re       = 1'b0;
    raddr    = rd_idx_q + AddrW'(1);
    case (cmd_i.op)
      BUF_BEGIN: begin
        we    = 1'b1;
        waddr = '0;
        len_d = LenW'(1);
        dot_d = 1'b0;
        ovf_d = 1'b0;
        for (int k = 0; k < KW_NUM; k++) begin
          kw_ok_d[k] = (cmd_i.chr == kw_char(k, 0));
        end
      end
      BUF_APPEND, BUF_APPEND_DOT: begin
        if (cmd_i.op == BUF_APPEND_DOT) begin
          dot_d = 1'b1;
        end
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          we    = 1'b1;
          len_d = len_q + LenW'(1);
          for (int k = 0; k < KW_NUM; k++) begin
            kw_ok_d[k] = kw_ok_q[k] & pos_ok &
                         (cmd_i.chr == kw_char(k, int'(len_q[2:0])));
          end
        end
      end
      BUF_CLEAR: begin
        len_d = '0;
        dot_d = 1'b0;
        ovf_d = 1'b0;
      end
      BUF_RD_FIRST: begin
        re       = 1'b1;
        raddr    = '0;
        rd_idx_d = '0;
      end
      BUF_RD_NEXT: begin
        re       = 1'b1;
        rd_idx_d = rd_idx_q + AddrW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= cmd_i.chr;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      rd_idx_q <= '0;
      dot_q    <= 1'b0;
      ovf_q    <= 1'b0;
      kw_ok_q  <= '0;
    end else begin
      len_q    <= len_d;
      rd_idx_q <= rd_idx_d;
      dot_q    <= dot_d;
      ovf_q    <= ovf_d;
      kw_ok_q  <= kw_ok_d;
    end
  end

  always_comb begin
    stat_o.kw_idx = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      kw_len_eq[k] = (len_q == LenW'(KW_LEN[k]));
    end
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (kw_ok_q[k] && kw_len_eq[k]) begin
        stat_o.kw_idx = 3'(k);
      end
    end
    stat_o.kw_hit     = !ovf_q && |(kw_ok_q & kw_len_eq);
    stat_o.overflowed = ovf_q;
    stat_o.seen_dot   = dot_q;
    stat_o.rd_last    = ((LenW'(rd_idx_q) + LenW'(1)) == len_q);
    stat_o.rd_char    = rdata_q;
  end

endmodule

>>> hdl/small_c_tokenizer.sv
// ----------------------------------------------------------------------------
// small_c_tokenizer
// Streaming lexical analyser for a small C-like language.
// ----------------------------------------------------------------------------
// Source bytes arrive on the input channel (ch_i, last_i), one per beat, and
// tokens leave on the output channel, one result per beat. Symbols and
// keywords give one beat; literals and identifiers give one beat per kept
// character, the last one flagged with end_of_token_o.
// The block works on one byte at a time. A byte that extends a lexeme or a
// comment, or completes a two-character operator, goes through the scan
// phase before the next input beat. A byte looked at from the idle mode (a
// symbol, an opener, skipped text, or a byte that ends a pending token) goes
// through the start phase as well. A lexeme is read out of the buffer memory
// one character per cycle while the receiver takes them; a keyword needs no
// read-out. The byte flagged by last_i also goes through the last phase and
// through the read-out of any lexeme still pending.
// The output register holds a result until it is taken; a stall holds the
// sequencer at its next result, while bytes that give none are still taken.
// Reset empties the output register, puts the scanner in its idle mode and
// sets the line counter to one; the buffer contents need no clearing, since
// only characters written for the current lexeme are read. The byte flagged
// by last_i flushes any pending token and returns the scanner to that state.
// ----------------------------------------------------------------------------
module small_c_tokenizer import sct_pkg::*; #(
  parameter int unsigned MaxLexeme = MAX_LEXEME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  kind_o,
  output logic [15:0] line_o,
  output logic [7:0]  lexeme_char_o,
  output logic        end_of_token_o,
  output logic        truncated_o
);

  // Scanner mode, one-hot.
  typedef enum logic [8:0] {
    M_IDLE  = 9'b000000001,
    M_SLASH = 9'b000000010,
    M_EQ    = 9'b000000100,
    M_GT    = 9'b000001000,
    M_LT    = 9'b000010000,
    M_COMM  = 9'b000100000,
    M_CSTAR = 9'b001000000,
    M_NUM   = 9'b010000000,
    M_IDENT = 9'b100000000
  } scan_mode_e;

  // Sequencer phase, one-hot. SCAN handles the current mode, START looks at
  // the byte from the idle mode, LAST flushes at the end of the text and
  // FLUSH reads a lexeme out of the buffer.
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SCAN  = 5'b00010,
    PH_START = 5'b00100,
    PH_LAST  = 5'b01000,
    PH_FLUSH = 5'b10000
  } phase_e;

  phase_e     phase_q, phase_d;
  scan_mode_e mode_q, mode_d;
  logic [7:0] ch_q, ch_d;
  logic       last_q, last_d;
  logic       ret_last_q, ret_last_d;
  logic [15:0] line_cnt_q, line_cnt_d;
  logic [15:0] tok_line_q, tok_line_d;

  buf_cmd_t   cmd;
  buf_stat_t  stat;

  logic       out_valid_q;
  logic [4:0] kind_q;
  logic [15:0] line_q;
  logic [7:0] chr_q;
  logic       eot_q;
  logic       trunc_q;

  logic       slot;
  logic       emit;
  logic [4:0] e_kind;
  logic [15:0] e_line;
  logic [7:0] e_chr;
  logic       e_eot;
  logic       e_trunc;

  logic       fin;
  logic       fl_req;
  logic       fl_ret;
  logic       fl_done;
  logic       done_ret;
  logic       lr;
  logic [4:0] lex_kind;
  logic [4:0] pend_kind;
  sym_t       sym;

  sct_lexbuf #(
    .MaxLexeme(MaxLexeme)
  ) u_lexbuf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .stat_o(stat)
  );

  // The output register can take a result this cycle.
  assign slot = !out_valid_q || out_ready_i;

  assign sym      = single_sym(ch_q);
  assign lex_kind = (mode_q == M_NUM) ? (stat.seen_dot ? K_REALLIT : K_INTLIT) : K_ID;

  // Token given by a lone '/', '=', '>' or '<' that found no partner.
  always_comb begin
    case (mode_q)
      M_SLASH: pend_kind = K_DIV;
      M_EQ:    pend_kind = K_ASSIGN;
      M_GT:    pend_kind = K_GT;
      default: pend_kind = K_LT;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    mode_d     = mode_q;
    ch_d       = ch_q;
    last_d     = last_q;
    ret_last_d = ret_last_q;
    line_cnt_d = line_cnt_q;
    tok_line_d = tok_line_q;
    cmd.op     = BUF_NONE;
    cmd.chr    = ch_q;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    e_kind     = K_SEMI;
    e_line     = tok_line_q;
    e_chr      = 8'h00;
    e_eot      = 1'b1;
    e_trunc    = 1'b0;
    fin        = 1'b0;
    fl_req     = 1'b0;
    fl_ret     = 1'b0;
    fl_done    = 1'b0;
    done_ret   = 1'b0;
    lr         = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d    = ch_i;
          last_d  = last_i;
          phase_d = PH_SCAN;
        end
      end

      PH_SCAN: begin
        case (mode_q)
          M_SLASH: begin
            if (ch_q == "*") begin
              mode_d = M_COMM;
              fin    = 1'b1;
            end else if (slot) begin
              emit    = 1'b1;
              e_kind  = K_DIV;
              mode_d  = M_IDLE;
              phase_d = PH_START;
            end
          end
          M_EQ, M_GT, M_LT: begin
            if (slot) begin
              emit   = 1'b1;
              mode_d = M_IDLE;
              if (ch_q == "=") begin
                e_kind = (mode_q == M_EQ) ? K_EQ : (mode_q == M_GT) ? K_GE : K_LE;
                fin    = 1'b1;
              end else if (ch_q == ">" && mode_q == M_LT) begin
                e_kind = K_NEQ;
                fin    = 1'b1;
              end else begin
                e_kind  = pend_kind;
                phase_d = PH_START;
              end
            end
          end
          M_COMM: begin
            if (ch_q == "*") begin
              mode_d = M_CSTAR;
            end
            fin = 1'b1;
          end
          M_CSTAR: begin
            if (ch_q == "/") begin
              mode_d = M_IDLE;
            end else if (ch_q != "*") begin
              mode_d = M_COMM;
            end
            fin = 1'b1;
          end
          M_NUM: begin
            if (is_digit(ch_q)) begin
              cmd.op = BUF_APPEND;
              fin    = 1'b1;
            end else if (ch_q == "." && !stat.seen_dot) begin
              cmd.op = BUF_APPEND_DOT;
              fin    = 1'b1;
            end else begin
              fl_req = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_digit(ch_q) || is_alpha(ch_q)) begin
              cmd.op = BUF_APPEND;
              fin    = 1'b1;
            end else begin
              fl_req = 1'b1;
            end
          end
          default: begin
            mode_d  = M_IDLE;
            phase_d = PH_START;
          end
        endcase
      end

      PH_START: begin
        // The scanner is idle here; the byte may open a new token.
        if (sym.hit) begin
          if (slot) begin
            emit   = 1'b1;
            e_kind = sym.kind;
            e_line = line_cnt_q;
            fin    = 1'b1;
          end
        end else begin
          fin = 1'b1;
          case (ch_q)
            "/": begin
              mode_d     = M_SLASH;
              tok_line_d = line_cnt_q;
            end
            "=": begin
              mode_d     = M_EQ;
              tok_line_d = line_cnt_q;
            end
            ">": begin
              mode_d     = M_GT;
              tok_line_d = line_cnt_q;
            end
            "<": begin
              mode_d     = M_LT;
              tok_line_d = line_cnt_q;
            end
            default: begin
              if (is_digit(ch_q)) begin
                cmd.op     = BUF_BEGIN;
                mode_d     = M_NUM;
                tok_line_d = line_cnt_q;
              end else if (is_alpha(ch_q)) begin
                cmd.op     = BUF_BEGIN;
                mode_d     = M_IDENT;
                tok_line_d = line_cnt_q;
              end
            end
          endcase
        end
      end

      PH_LAST: begin
        if (mode_q == M_NUM || mode_q == M_IDENT) begin
          fl_req = 1'b1;
          fl_ret = 1'b1;
        end else if (mode_q == M_SLASH || mode_q == M_EQ ||
                     mode_q == M_GT || mode_q == M_LT) begin
          if (slot) begin
            emit    = 1'b1;
            e_kind  = pend_kind;
            lr      = 1'b1;
            phase_d = PH_IDLE;
          end
        end else begin
          lr      = 1'b1;
          phase_d = PH_IDLE;
        end
      end

      PH_FLUSH: begin
        if (slot) begin
          emit    = 1'b1;
          e_kind  = lex_kind;
          e_chr   = stat.rd_char;
          e_eot   = stat.rd_last;
          e_trunc = stat.overflowed;
          if (stat.rd_last) begin
            fl_done  = 1'b1;
            done_ret = ret_last_q;
          end else begin
            cmd.op = BUF_RD_NEXT;
          end
        end
      end

      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // Start a flush: a keyword is one beat, anything else is read out of
    // the buffer from its first character.
    if (fl_req) begin
      if (stat.kw_hit) begin
        if (slot) begin
          emit     = 1'b1;
          e_kind   = K_KW0 + {2'b00, stat.kw_idx};
          fl_done  = 1'b1;
          done_ret = fl_ret;
        end
      end else begin
        cmd.op     = BUF_RD_FIRST;
        ret_last_d = fl_ret;
        phase_d    = PH_FLUSH;
      end
    end

    if (fl_done) begin
      if (done_ret) begin
        lr      = 1'b1;
        phase_d = PH_IDLE;
      end else begin
        mode_d  = M_IDLE;
        phase_d = PH_START;
      end
    end

    // Byte handled; count the line unless the text ends here.
    if (fin) begin
      if (last_q) begin
        phase_d = PH_LAST;
      end else begin
        if (ch_q == "\n" && line_cnt_q != 16'hFFFF) begin
          line_cnt_d = line_cnt_q + 16'd1;
        end
        phase_d = PH_IDLE;
      end
    end

    // End of text: back to the state after reset.
    if (lr) begin
      mode_d     = M_IDLE;
      cmd.op     = BUF_CLEAR;
      line_cnt_d = 16'd1;
      tok_line_d = 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      mode_q      <= M_IDLE;
      ret_last_q  <= 1'b0;
      line_cnt_q  <= 16'd1;
      tok_line_q  <= 16'd1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mode_q      <= mode_d;
      ret_last_q  <= ret_last_d;
      line_cnt_q  <= line_cnt_d;
      tok_line_q  <= tok_line_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    last_q <= last_d;
    if (emit) begin
      kind_q  <= e_kind;
      line_q  <= e_line;
      chr_q   <= e_chr;
      eot_q   <= e_eot;
      trunc_q <= e_trunc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign line_o         = line_q;
  assign lexeme_char_o  = chr_q;
  assign end_of_token_o = eot_q;
  assign truncated_o    = trunc_q;

endmodule
